[sv/lamp_button_timer_controller_macros.svh]
// Assertion macros shared by the lamp controller RTL.
// Needs nothing else; included by the modules that carry assertions.
`ifndef LAMP_BUTTON_TIMER_CONTROLLER_MACROS_SVH
`define LAMP_BUTTON_TIMER_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LBT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define LBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/lbt_pkg.sv]
// Shared types, codes and reset constants for the lamp controller.
// No dependencies; used by every module of the block.
package lbt_pkg;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_DEFAULT_LEVEL = 3'd0;
   localparam logic [2:0] CSR_MAX_LEVEL     = 3'd1;
   localparam logic [2:0] CSR_DEBOUNCE_MS   = 3'd2;
   localparam logic [2:0] CSR_LONG_PRESS_MS = 3'd3;
   localparam logic [2:0] CSR_AUTO_OFF_MS   = 3'd4;

   // Command codes
   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_ONOFF  = 2'd1;
   localparam logic [1:0] ACT_BRIGHT = 2'd2;
   localparam logic [1:0] ACT_EFFECT = 2'd3;

   // Effect codes
   localparam logic [1:0] EFF_CONSTANT = 2'd0;
   localparam logic [1:0] EFF_TIMER    = 2'd1;
   localparam logic [1:0] EFF_FADE     = 2'd2;

   localparam logic [6:0] LEVEL_TOP = 7'd99;

   // Register reset values
   localparam logic [6:0]  RST_DEFAULT_LEVEL = 7'd25;
   localparam logic [6:0]  RST_MAX_LEVEL     = 7'd50;
   localparam logic [15:0] RST_DEBOUNCE_MS   = 16'd200;
   localparam logic [15:0] RST_LONG_PRESS_MS = 16'd1000;
   localparam logic [31:0] RST_AUTO_OFF_MS   = 32'd30000;
   localparam logic [6:0]  RST_CUR_LEVEL     = 7'd25;

   localparam int QUEUE_DEPTH = 4;

   // One status report
   typedef struct packed {
      logic       lamp_lit;
      logic [6:0] level;
      logic [1:0] effect;
      logic [6:0] duty;
      logic       last;
   } report_type;

   // Everything one tick produces: one or two reports
   typedef struct packed {
      logic       two;
      report_type rep1;
      report_type rep0;
   } entry_type;

   // Front to queue write bundle
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   // Queue to back read bundle
   typedef struct packed {
      logic      empty;
      entry_type head;
   } head_type;

endpackage

[sv/lbt_front.sv]
// Tick processor: configuration registers, lamp state, button and timer logic.
// Depends on lbt_pkg; pushes the reports of each tick into lbt_queue.
module lbt_front (
   input  logic                clock,
   input  logic                reset,
   // request
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [6:0] msg_value, [7] button_level
   input  logic [1:0]          req_tuser,   // [1:0] action
   // configuration
   input  logic                csr_valid,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data,
   // queue side
   input  logic                q_full,
   output lbt_pkg::push_type   push
);

   logic [6:0]  default_level_ff, max_level_ff;
   logic [15:0] debounce_ff, long_press_ff;
   logic [31:0] auto_off_ff;

   logic [31:0] now_ff, now_in;
   logic [31:0] last_press_ff, last_press_in;
   logic [31:0] deadline_ff, deadline_in;
   logic        on_ff, on_in;
   logic        prev_on_ff, prev_on_in;
   logic [6:0]  lvl_ff, lvl_in;
   logic [6:0]  prev_lvl_ff, prev_lvl_in;
   logic [1:0]  eff_ff, eff_in;
   logic        prev_btn_ff, prev_btn_in;
   logic [6:0]  duty_ff, duty_in;

   logic [6:0]  msg_value;
   logic        button_level;
   logic [1:0]  action;
   logic        fire;
   logic        eff_rep;
   logic        changed;
   logic [31:0] elapsed;
   logic [31:0] deadline_sum;
   lbt_pkg::report_type eff_report, chg_report;

   assign msg_value    = req_tdata[6:0];
   assign button_level = req_tdata[7];
   assign action       = req_tuser;
   assign req_tready   = ~q_full;
   assign fire         = req_tvalid & req_tready;
   assign elapsed      = now_ff - last_press_ff;
   assign deadline_sum = now_ff + auto_off_ff;

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         default_level_ff <= lbt_pkg::RST_DEFAULT_LEVEL;
         max_level_ff     <= lbt_pkg::RST_MAX_LEVEL;
         debounce_ff      <= lbt_pkg::RST_DEBOUNCE_MS;
         long_press_ff    <= lbt_pkg::RST_LONG_PRESS_MS;
         auto_off_ff      <= lbt_pkg::RST_AUTO_OFF_MS;
      end else if (csr_valid) begin
         case (csr_index)
            lbt_pkg::CSR_DEFAULT_LEVEL: default_level_ff <= csr_data[6:0];
            lbt_pkg::CSR_MAX_LEVEL:     max_level_ff     <= csr_data[6:0];
            lbt_pkg::CSR_DEBOUNCE_MS:   debounce_ff      <= csr_data[15:0];
            lbt_pkg::CSR_LONG_PRESS_MS: long_press_ff    <= csr_data[15:0];
            lbt_pkg::CSR_AUTO_OFF_MS:   auto_off_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // Next state of one tick: command, button edge, auto-off, change check
   always_comb begin
      now_in        = now_ff + 32'd1;
      last_press_in = last_press_ff;
      deadline_in   = deadline_ff;
      on_in         = on_ff;
      lvl_in        = lvl_ff;
      eff_in        = eff_ff;
      prev_btn_in   = prev_btn_ff;
      prev_on_in    = prev_on_ff;
      prev_lvl_in   = prev_lvl_ff;
      duty_in       = duty_ff;
      eff_rep       = 1'b0;

      // command
      case (action)
         lbt_pkg::ACT_ONOFF: begin
            on_in  = (msg_value == 7'd1);
            lvl_in = on_in ? default_level_ff : 7'd0;
         end
         lbt_pkg::ACT_BRIGHT: begin
            lvl_in = (msg_value > lbt_pkg::LEVEL_TOP) ? lbt_pkg::LEVEL_TOP : msg_value;
            on_in  = (lvl_in != 7'd0);
         end
         lbt_pkg::ACT_EFFECT: begin
            eff_in  = (msg_value < 7'd2) ? msg_value[1:0] : lbt_pkg::EFF_FADE;
            eff_rep = 1'b1;
         end
         default: ;
      endcase

      // button edge
      if (button_level != prev_btn_ff) begin
         if (!button_level) begin
            if (elapsed > {16'd0, debounce_ff})
               last_press_in = now_ff;
         end else if (elapsed < {16'd0, long_press_ff}) begin
            on_in       = ~on_in;
            lvl_in      = on_in ? default_level_ff : 7'd0;
            deadline_in = 32'd0;
            eff_in      = lbt_pkg::EFF_CONSTANT;
         end else begin
            on_in       = 1'b1;
            lvl_in      = default_level_ff;
            eff_in      = lbt_pkg::EFF_TIMER;
            deadline_in = deadline_sum;
         end
         prev_btn_in = button_level;
      end

      // auto-off; a zero deadline means the timer is idle
      if ((deadline_in != 32'd0) && (now_ff >= deadline_in)) begin
         on_in       = 1'b0;
         deadline_in = 32'd0;
         eff_in      = lbt_pkg::EFF_CONSTANT;
      end

      changed = (prev_on_ff != on_in) || (prev_lvl_ff != lvl_in);

      // effect report sees the level before clamping and the old duty
      eff_report.lamp_lit = on_in;
      eff_report.level    = lvl_in;
      eff_report.effect   = eff_in;
      eff_report.duty     = duty_ff;
      eff_report.last     = ~changed;

      // change check: clamp and recompute duty
      if (changed) begin
         if (!on_in)
            lvl_in = 7'd0;
         if (lvl_in == 7'd0) begin
            duty_in = on_in ? default_level_ff : 7'd0;
         end else begin
            if (lvl_in > max_level_ff)
               lvl_in = max_level_ff;
            duty_in = lvl_in;
         end
         prev_on_in  = on_in;
         prev_lvl_in = lvl_in;
      end

      chg_report.lamp_lit = on_in;
      chg_report.level    = lvl_in;
      chg_report.effect   = eff_in;
      chg_report.duty     = duty_in;
      chg_report.last     = 1'b1;
   end

   // Queue write: effect report first when both are present
   always_comb begin
      push.valid      = fire & (eff_rep | changed);
      push.entry.two  = eff_rep & changed;
      push.entry.rep0 = eff_rep ? eff_report : chg_report;
      push.entry.rep1 = chg_report;
   end

   // Lamp state advances once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff        <= 32'd0;
         last_press_ff <= 32'd0;
         deadline_ff   <= 32'd0;
         on_ff         <= 1'b0;
         prev_on_ff    <= 1'b0;
         lvl_ff        <= lbt_pkg::RST_CUR_LEVEL;
         prev_lvl_ff   <= lbt_pkg::RST_CUR_LEVEL;
         eff_ff        <= lbt_pkg::EFF_CONSTANT;
         prev_btn_ff   <= 1'b1;
         duty_ff       <= 7'd0;
      end else if (fire) begin
         now_ff        <= now_in;
         last_press_ff <= last_press_in;
         deadline_ff   <= deadline_in;
         on_ff         <= on_in;
         prev_on_ff    <= prev_on_in;
         lvl_ff        <= lvl_in;
         prev_lvl_ff   <= prev_lvl_in;
         eff_ff        <= eff_in;
         prev_btn_ff   <= prev_btn_in;
         duty_ff       <= duty_in;
      end
   end

endmodule

[sv/lbt_queue.sv]
// Short FIFO of per-tick report entries between front and back.
// Depends on lbt_pkg and the assertion macro header.
`include "lamp_button_timer_controller_macros.svh"

module lbt_queue #(
   parameter int DEPTH = lbt_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  lbt_pkg::push_type push,
   input  logic              pop,
   output logic              full,
   output lbt_pkg::head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   lbt_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               wr_fire, rd_fire;

   assign full       = (count_ff == CNT_FULL);
   assign head.empty = (count_ff == '0);
   assign head.head  = mem_ff[rd_ptr_ff];
   assign wr_fire    = push.valid & ~full;
   assign rd_fire    = pop & ~head.empty;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_fire ? ((wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = rd_fire ? ((rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_fire && !rd_fire)
         count_in = count_ff + 1'b1;
      else if (!wr_fire && rd_fire)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (wr_fire)
         mem_ff[wr_ptr_ff] <= push.entry;
   end

   `LBT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL, "queue overfilled")
   `LBT_ASSERT_NEXT(a_push_grows, clock, reset, wr_fire && !rd_fire, count_ff == $past(count_ff) + 1'b1, "push lost")

endmodule

[sv/lbt_back.sv]
// Report serializer: plays one or two reports of the head entry on rsp.
// Depends on lbt_pkg and the assertion macro header.
`include "lamp_button_timer_controller_macros.svh"

module lbt_back (
   input  logic              clock,
   input  logic              reset,
   input  lbt_pkg::head_type head,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // [0] lamp_lit, [7:1] level, [9:8] effect,
                                          // [16:10] duty, rest zero
   output logic              rsp_tlast
);

   logic                sel_ff, sel_in;
   logic                fire;
   lbt_pkg::report_type rep;

   assign rsp_tvalid = ~head.empty;
   assign fire       = rsp_tvalid & rsp_tready;
   assign rep        = sel_ff ? head.head.rep1 : head.head.rep0;
   assign pop        = fire & (sel_ff | ~head.head.two);
   assign rsp_tdata  = {7'd0, rep.duty, rep.effect, rep.level, rep.lamp_lit};
   assign rsp_tlast  = rep.last;

   // Second-report select
   always_comb begin
      sel_in = sel_ff;
      if (fire)
         sel_in = ~sel_ff & head.head.two;
   end

   always_ff @(posedge clock) begin
      if (reset)
         sel_ff <= 1'b0;
      else
         sel_ff <= sel_in;
   end

   `LBT_ASSERT_NOW(a_second_is_last, clock, reset, rsp_tvalid && sel_ff, rsp_tlast, "second report not last")
   `LBT_ASSERT_NEXT(a_pair_advance, clock, reset, fire && head.head.two && !sel_ff, sel_ff, "pair skipped")

endmodule

[sv/lamp_button_timer_controller.sv]
// Reports enter the report queue when their tick is accepted on req.
// Throughput: one tick per cycle while the queue has room; the single rsp port
// sends one report per cycle while rsp_tready is high; paired reports go in turn.
// Reset (synchronous, active high) restores register defaults and lamp state
// and empties the report queue.
// Depends on lbt_pkg, lbt_front, lbt_queue and lbt_back.
module lamp_button_timer_controller #(
   parameter int QUEUE_DEPTH = lbt_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // tick requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [6:0] msg_value, [7] button_level
   input  logic [1:0]  req_tuser,    // [1:0] action
   // status reports
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [0] lamp_lit, [7:1] level, [9:8] effect,
                                     // [16:10] duty, rest zero
   output logic        rsp_tlast,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   lbt_pkg::push_type push;
   lbt_pkg::head_type head;
   logic              q_full;
   logic              pop;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   lbt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid & csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .push       (push)
   );

   lbt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   lbt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
